>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the height to color mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HTCM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("htcm assertion failed");
`define HTCM_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("htcm assertion failed");
`else
`define HTCM_ASSERT(label, clk, rst_n, prop)
`define HTCM_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> hw/rtl/htcm_pkg.sv
// Types and constants of the height to color mapper.
package htcm_pkg;

    localparam int HEIGHT_BITS_DEFAULT   = 16;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int COLOR_BITS     = 24;
    localparam int CHANNEL_BITS   = 8;
    localparam int NUM_BANDS      = 5;
    localparam int PHASE_BITS     = 9;
    localparam int HUE_BITS       = 17;
    localparam int SECTOR_BITS    = 3;
    localparam int U_BITS         = 14;

    localparam logic [PHASE_BITS-1:0] PHASE_STEP = 9'd2;
    localparam logic [PHASE_BITS-1:0] PHASE_WRAP = 9'd360;
    localparam logic [HUE_BITS-1:0]   SECTOR_Q8  = 17'd15360;
    localparam logic [HUE_BITS-1:0]   FULL_Q8    = 17'd92160;

    localparam logic [CHANNEL_BITS-1:0] CHANNEL_MAX = 8'd255;

    localparam logic [1:0] MODE_BANDS    = 2'd0;
    localparam logic [1:0] MODE_GRADIENT = 2'd1;
    localparam logic [1:0] MODE_RAINBOW  = 2'd2;

    localparam logic OP_COLOR = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLOR_MODE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND0      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND1      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND2      = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND3      = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND4      = 3'd7;

    typedef logic [NUM_BANDS-1:0][COLOR_BITS-1:0] band_array_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CHECK,
        ST_DIVIDE,
        ST_HUE,
        ST_SECTOR,
        ST_COLOR
    } state_t;

endpackage

>>> hw/rtl/htcm_divider.sv
// Restoring divider that yields one fraction bit per cycle.
`include "assert_macros.svh"

module htcm_divider #(
    parameter int HEIGHT_BITS   = htcm_pkg::HEIGHT_BITS_DEFAULT,
    parameter int FRACTION_BITS = htcm_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [HEIGHT_BITS-1:0]   dividend,
    input  logic [HEIGHT_BITS-1:0]   divisor,
    output logic [FRACTION_BITS-1:0] quotient,
    output logic                     done
);

    localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);

    logic                     busy_reg;
    logic                     busy_next;
    logic                     done_reg;
    logic                     done_next;
    logic [CNT_BITS-1:0]      count_reg;
    logic [CNT_BITS-1:0]      count_next;
    logic [HEIGHT_BITS-1:0]   rem_reg;
    logic [HEIGHT_BITS-1:0]   rem_next;
    logic [HEIGHT_BITS-1:0]   divisor_reg;
    logic [HEIGHT_BITS-1:0]   divisor_next;
    logic [FRACTION_BITS-1:0] quo_reg;
    logic [FRACTION_BITS-1:0] quo_next;
    logic [HEIGHT_BITS:0]     shifted;
    logic [HEIGHT_BITS:0]     diff;
    logic                     fits;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        quo_next     = quo_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = CNT_BITS'(FRACTION_BITS);
            rem_next     = dividend;
            divisor_next = divisor;
            quo_next     = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[HEIGHT_BITS-1:0] : shifted[HEIGHT_BITS-1:0];
            quo_next   = {quo_reg[FRACTION_BITS-2:0], fits};
            count_next = count_reg - CNT_BITS'(1);
            if (count_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    `HTCM_ASSERT(a_div_count_live, clk, rst_n, busy_reg |-> count_reg != '0)
    `HTCM_ASSERT(a_div_rem_below, clk, rst_n, busy_reg |-> rem_reg < divisor_reg)
    `HTCM_ASSERT(a_div_no_restart, clk, rst_n, start |-> !busy_reg)

endmodule

>>> hw/rtl/htcm_color.sv
// Color selection for the band, gradient and rainbow modes.
module htcm_color #(
    parameter int FRACTION_BITS = htcm_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic [1:0]                          mode,
    input  logic [FRACTION_BITS:0]              frac,
    input  logic [htcm_pkg::SECTOR_BITS-1:0]    sector,
    input  logic [htcm_pkg::U_BITS-1:0]         u,
    input  htcm_pkg::band_array_t               bands,
    output logic [htcm_pkg::COLOR_BITS-1:0]     color
);

    localparam int FW = FRACTION_BITS + 1;
    localparam int PW = FRACTION_BITS + 9;
    localparam longint unsigned ONE = longint'(1) << FRACTION_BITS;
    localparam logic [FW-1:0] T1 = FW'((ONE * 1 + 5) / 10);
    localparam logic [FW-1:0] T3 = FW'((ONE * 3 + 5) / 10);
    localparam logic [FW-1:0] T5 = FW'((ONE * 5 + 5) / 10);
    localparam logic [FW-1:0] T7 = FW'((ONE * 7 + 5) / 10);

    logic [PW-1:0]                         prod_r;
    logic [PW-1:0]                         prod_g;
    logic [PW-1:0]                         prod_b;
    logic [htcm_pkg::CHANNEL_BITS-1:0]     ramp_r;
    logic [htcm_pkg::CHANNEL_BITS-1:0]     ramp_g;
    logic [htcm_pkg::CHANNEL_BITS-1:0]     ramp_b;
    logic [htcm_pkg::U_BITS+4:0]           x_prod;
    logic [htcm_pkg::CHANNEL_BITS-1:0]     x;
    logic [htcm_pkg::CHANNEL_BITS-1:0]     c;
    logic [htcm_pkg::COLOR_BITS-1:0]       band_color;
    logic [htcm_pkg::COLOR_BITS-1:0]       ramp_color;
    logic [htcm_pkg::COLOR_BITS-1:0]       rainbow_color;

    assign prod_r = PW'(frac) * PW'(8'h66);
    assign prod_g = PW'(frac) * PW'(8'hCC);
    assign prod_b = PW'(frac) * PW'(8'h99);
    assign ramp_r = prod_r[FRACTION_BITS+7:FRACTION_BITS];
    assign ramp_g = prod_g[FRACTION_BITS+7:FRACTION_BITS];
    assign ramp_b = 8'h66 + prod_b[FRACTION_BITS+7:FRACTION_BITS];
    assign ramp_color = {ramp_r, ramp_g, ramp_b};

    // The sector spans 15360 Q8 degrees, so 255 * u / 15360 reduces to 17 * u / 1024.
    assign x_prod = {u, 4'b0000} + (htcm_pkg::U_BITS + 5)'(u);
    assign x      = x_prod[htcm_pkg::U_BITS+3:10];
    assign c      = htcm_pkg::CHANNEL_MAX;

    always_comb
    begin
        priority if (frac < T1)
        begin
            band_color = bands[0];
        end
        else if (frac < T3)
        begin
            band_color = bands[1];
        end
        else if (frac < T5)
        begin
            band_color = bands[2];
        end
        else if (frac < T7)
        begin
            band_color = bands[3];
        end
        else
        begin
            band_color = bands[4];
        end
    end

    always_comb
    begin
        unique case (sector)
            3'd0:    rainbow_color = {c, x, 8'h00};
            3'd1:    rainbow_color = {x, c, 8'h00};
            3'd2:    rainbow_color = {8'h00, c, x};
            3'd3:    rainbow_color = {8'h00, x, c};
            3'd4:    rainbow_color = {x, 8'h00, c};
            default: rainbow_color = {c, 8'h00, x};
        endcase
    end

    always_comb
    begin
        unique case (mode)
            htcm_pkg::MODE_GRADIENT: color = ramp_color;
            htcm_pkg::MODE_RAINBOW:  color = rainbow_color;
            default:                 color = band_color;
        endcase
    end

endmodule

>>> hw/rtl/height_to_color_mapper.sv
// Height to color mapper: sequencer, configuration registers and output register.
//
// Usage: a request on the input channel carries an operation and a height. A color
// request yields one 24-bit RGB result on the output channel; a tick request
// yields none and, in rainbow mode, advances the hue phase by two degrees.
// Registers are written through the configuration channel, index 0 mode,
// 1 and 2 the height range, 3 to 7 the band colors; the user must write
// them only while no request is in flight, the block does not enforce it.
// The configuration channel is always ready.
// A color request passes through the DIFF, CHECK, DIVIDE, HUE, SECTOR and
// COLOR states, the divider producing one fraction bit per cycle; requests
// that need no division (zero range, height at or beyond a range end) skip
// DIVIDE. One request is in work at a time and in_ready is low meanwhile.
// A finished color sits in the output register; the next request is
// accepted while it waits, and the sequencer holds its next color until
// the receiver takes the previous one with out_ready.
// Reset clears the mode, the range, the band colors and the hue phase to
// zero and empties the output register.
`include "assert_macros.svh"

module height_to_color_mapper #(
    parameter int HEIGHT_BITS   = htcm_pkg::HEIGHT_BITS_DEFAULT,
    parameter int FRACTION_BITS = htcm_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  operation,
    input  logic signed [HEIGHT_BITS-1:0]         height,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [htcm_pkg::COLOR_BITS-1:0]       color,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [htcm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [htcm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int HB = HEIGHT_BITS;
    localparam int FB = FRACTION_BITS;
    localparam logic [FB:0] FRAC_ONE = {1'b1, {FB{1'b0}}};

    htcm_pkg::state_t                       state_reg;
    htcm_pkg::state_t                       state_next;
    logic [1:0]                             mode_reg;
    logic [HB-1:0]                          min_reg;
    logic [HB-1:0]                          max_reg;
    htcm_pkg::band_array_t                  band_reg;
    logic [htcm_pkg::PHASE_BITS-1:0]        phase_reg;
    logic [htcm_pkg::PHASE_BITS-1:0]        phase_next;
    logic [HB-1:0]                          height_reg;
    logic [HB-1:0]                          height_next;
    logic [HB:0]                            num_reg;
    logic [HB:0]                            num_next;
    logic [HB:0]                            den_reg;
    logic [HB:0]                            den_next;
    logic [FB:0]                            frac_reg;
    logic [FB:0]                            frac_next;
    logic [htcm_pkg::HUE_BITS-1:0]          hue_reg;
    logic [htcm_pkg::HUE_BITS-1:0]          hue_next;
    logic [htcm_pkg::SECTOR_BITS-1:0]       sector_reg;
    logic [htcm_pkg::SECTOR_BITS-1:0]       sector_next;
    logic [htcm_pkg::U_BITS-1:0]            u_reg;
    logic [htcm_pkg::U_BITS-1:0]            u_next;
    logic [htcm_pkg::COLOR_BITS-1:0]        color_reg;
    logic [htcm_pkg::COLOR_BITS-1:0]        color_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;

    logic [htcm_pkg::PHASE_BITS-1:0]        phase_step;
    logic [HB:0]                            num_neg;
    logic [HB:0]                            den_neg;
    logic [HB-1:0]                          num_abs;
    logic [HB-1:0]                          den_abs;
    logic                                   div_start;
    logic                                   div_done;
    logic [FB-1:0]                          quotient;
    logic [FB+9:0]                          hue_prod;
    logic [htcm_pkg::HUE_BITS:0]            hue_sum;
    logic [htcm_pkg::SECTOR_BITS-1:0]       sector_sel;
    logic [htcm_pkg::HUE_BITS-1:0]          sector_base;
    logic [htcm_pkg::U_BITS-1:0]            t_val;
    logic [htcm_pkg::COLOR_BITS-1:0]        mapped;

    assign phase_step = phase_reg + htcm_pkg::PHASE_STEP;
    assign num_neg    = -num_reg;
    assign den_neg    = -den_reg;
    assign num_abs    = num_reg[HB] ? num_neg[HB-1:0] : num_reg[HB-1:0];
    assign den_abs    = den_reg[HB] ? den_neg[HB-1:0] : den_reg[HB-1:0];
    assign hue_prod   = (FB + 10)'(frac_reg) * (FB + 10)'(360);
    assign hue_sum    = {1'b0, hue_prod[FB+8:FB-8]} + {1'b0, phase_reg, 8'h00};

    always_comb
    begin
        priority if (hue_reg >= 17'(5) * htcm_pkg::SECTOR_Q8)
        begin
            sector_sel = 3'd5;
        end
        else if (hue_reg >= 17'(4) * htcm_pkg::SECTOR_Q8)
        begin
            sector_sel = 3'd4;
        end
        else if (hue_reg >= 17'(3) * htcm_pkg::SECTOR_Q8)
        begin
            sector_sel = 3'd3;
        end
        else if (hue_reg >= 17'(2) * htcm_pkg::SECTOR_Q8)
        begin
            sector_sel = 3'd2;
        end
        else if (hue_reg >= htcm_pkg::SECTOR_Q8)
        begin
            sector_sel = 3'd1;
        end
        else
        begin
            sector_sel = 3'd0;
        end
    end

    assign sector_base = 17'(sector_sel) * htcm_pkg::SECTOR_Q8;
    assign t_val       = htcm_pkg::U_BITS'(hue_reg - sector_base);

    htcm_divider #(
        .HEIGHT_BITS   (HEIGHT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_abs),
        .divisor  (den_abs),
        .quotient (quotient),
        .done     (div_done)
    );

    htcm_color #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_color (
        .mode   (mode_reg),
        .frac   (frac_reg),
        .sector (sector_reg),
        .u      (u_reg),
        .bands  (band_reg),
        .color  (mapped)
    );

    always_comb
    begin
        state_next     = state_reg;
        div_start      = 1'b0;
        phase_next     = phase_reg;
        height_next    = height_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        frac_next      = frac_reg;
        hue_next       = hue_reg;
        sector_next    = sector_reg;
        u_next         = u_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            htcm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == htcm_pkg::OP_TICK)
                    begin
                        if (mode_reg == htcm_pkg::MODE_RAINBOW)
                        begin
                            phase_next = (phase_step >= htcm_pkg::PHASE_WRAP) ?
                                         phase_step - htcm_pkg::PHASE_WRAP : phase_step;
                        end
                    end
                    else
                    begin
                        height_next = height;
                        state_next  = htcm_pkg::ST_DIFF;
                    end
                end
            end
            htcm_pkg::ST_DIFF:
            begin
                num_next   = {height_reg[HB-1], height_reg} - {min_reg[HB-1], min_reg};
                den_next   = {max_reg[HB-1], max_reg} - {min_reg[HB-1], min_reg};
                state_next = htcm_pkg::ST_CHECK;
            end
            htcm_pkg::ST_CHECK:
            begin
                priority if (den_reg == '0)
                begin
                    frac_next  = FRAC_ONE;
                    state_next = htcm_pkg::ST_HUE;
                end
                else if (num_reg == '0 || num_reg[HB] != den_reg[HB])
                begin
                    frac_next  = '0;
                    state_next = htcm_pkg::ST_HUE;
                end
                else if (num_abs >= den_abs)
                begin
                    frac_next  = FRAC_ONE;
                    state_next = htcm_pkg::ST_HUE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = htcm_pkg::ST_DIVIDE;
                end
            end
            htcm_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    frac_next  = {1'b0, quotient};
                    state_next = htcm_pkg::ST_HUE;
                end
            end
            htcm_pkg::ST_HUE:
            begin
                hue_next   = (hue_sum >= {1'b0, htcm_pkg::FULL_Q8}) ?
                             htcm_pkg::HUE_BITS'(hue_sum - {1'b0, htcm_pkg::FULL_Q8}) :
                             hue_sum[htcm_pkg::HUE_BITS-1:0];
                state_next = htcm_pkg::ST_SECTOR;
            end
            htcm_pkg::ST_SECTOR:
            begin
                sector_next = sector_sel;
                u_next      = sector_sel[0] ?
                              htcm_pkg::U_BITS'(htcm_pkg::SECTOR_Q8) - t_val : t_val;
                state_next  = htcm_pkg::ST_COLOR;
            end
            htcm_pkg::ST_COLOR:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    color_next     = mapped;
                    out_valid_next = 1'b1;
                    state_next     = htcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = htcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htcm_pkg::ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        frac_reg   <= frac_next;
        hue_reg    <= hue_next;
        sector_reg <= sector_next;
        u_reg      <= u_next;
        color_reg  <= color_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= htcm_pkg::MODE_BANDS;
            min_reg  <= '0;
            max_reg  <= '0;
            band_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                htcm_pkg::CFG_COLOR_MODE: mode_reg    <= cfg_data[1:0];
                htcm_pkg::CFG_MIN_HEIGHT: min_reg     <= cfg_data[HB-1:0];
                htcm_pkg::CFG_MAX_HEIGHT: max_reg     <= cfg_data[HB-1:0];
                htcm_pkg::CFG_BAND0:      band_reg[0] <= cfg_data[htcm_pkg::COLOR_BITS-1:0];
                htcm_pkg::CFG_BAND1:      band_reg[1] <= cfg_data[htcm_pkg::COLOR_BITS-1:0];
                htcm_pkg::CFG_BAND2:      band_reg[2] <= cfg_data[htcm_pkg::COLOR_BITS-1:0];
                htcm_pkg::CFG_BAND3:      band_reg[3] <= cfg_data[htcm_pkg::COLOR_BITS-1:0];
                htcm_pkg::CFG_BAND4:      band_reg[4] <= cfg_data[htcm_pkg::COLOR_BITS-1:0];
                default:                  mode_reg    <= mode_reg;
            endcase
        end
    end

    assign in_ready  = (state_reg == htcm_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign color     = color_reg;
    assign cfg_ready = 1'b1;

    `HTCM_ASSERT(a_start_divides, clk, rst_n, div_start |=> state_reg == htcm_pkg::ST_DIVIDE)
    `HTCM_ASSERT(a_frac_in_range, clk, rst_n, state_reg == htcm_pkg::ST_HUE |-> frac_reg <= FRAC_ONE)
    `HTCM_ASSERT(a_hue_reduced, clk, rst_n,
        state_reg == htcm_pkg::ST_SECTOR |-> hue_reg < htcm_pkg::FULL_Q8)
    `HTCM_ASSERT(a_phase_even, clk, rst_n,
        phase_reg < htcm_pkg::PHASE_WRAP && phase_reg[0] == 1'b0)
    `HTCM_ASSERT(a_result_after_color, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg) == htcm_pkg::ST_COLOR)

endmodule

>>> verif/height_to_color_mapper_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for height_to_color_mapper: directed edges, then randomized requests.
module height_to_color_mapper_tb;
    import htcm_pkg::*;

    localparam int HEIGHT_W = HEIGHT_BITS_DEFAULT;
    localparam int FRAC_W = FRACTION_BITS_DEFAULT;
    localparam int HEIGHT_MIN = -32768;
    localparam int HEIGHT_MAX = 32767;
    localparam longint FRAC_ONE = longint'(1) << FRAC_W;
    localparam longint SECTOR = SECTOR_Q8;
    localparam longint FULL_TURN = FULL_Q8;
    localparam longint GRAD_RED_TOP = 'h66;
    localparam longint GRAD_GREEN_TOP = 'hCC;
    localparam longint GRAD_BLUE_BASE = 'h66;
    localparam longint GRAD_BLUE_SPAN = 'h99;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int IDLE_PERCENT = 28;
    localparam int NUM_SETTINGS = 12;
    localparam int ITEMS_PER_SETTING = 170;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES = FRAC_W + 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS = 50;

    localparam band_array_t DIRECTED_BANDS =
        {24'h00FF00, 24'hABCDEF, 24'h123456, 24'hFFFFFF, 24'h000000};
    localparam int BAND_EDGES [10] =
        '{-32768, -1000, -801, -800, -400, -399, 0, 400, 1000, 32767};

    class color_scoreboard;
        logic [1:0] mode;
        logic signed [HEIGHT_W-1:0] min_h;
        logic signed [HEIGHT_W-1:0] max_h;
        band_array_t band;
        int unsigned phase;
        logic [COLOR_BITS-1:0] pending_colors [$];
        int mismatches;
        int checked;
        int ticks;
        int phase_steps;
        int colors_by_mode [4];

        function new();
            mode = MODE_BANDS;
            min_h = '0;
            max_h = '0;
            band = '0;
            phase = 0;
            mismatches = 0;
            checked = 0;
            ticks = 0;
            phase_steps = 0;
            for (int m = 0; m < 4; m++) colors_by_mode[m] = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_COLOR_MODE: mode = data[1:0];
                CFG_MIN_HEIGHT: min_h = data[HEIGHT_W-1:0];
                CFG_MAX_HEIGHT: max_h = data[HEIGHT_W-1:0];
                default: band[idx - CFG_BAND0] = data[COLOR_BITS-1:0];
            endcase
        endfunction

        function longint height_fraction(logic signed [HEIGHT_W-1:0] h);
            longint num;
            longint den;
            longint q;
            num = longint'(h) - longint'(min_h);
            den = longint'(max_h) - longint'(min_h);
            if (den == 0) return FRAC_ONE;
            if (num == 0 || ((num < 0) != (den < 0))) return 0;
            if (num < 0) num = -num;
            if (den < 0) den = -den;
            q = (num << FRAC_W) / den;
            return (q > FRAC_ONE) ? FRAC_ONE : q;
        endfunction

        function longint band_limit(int tenths);
            return (FRAC_ONE * tenths + 5) / 10;
        endfunction

        function logic [COLOR_BITS-1:0] altitude_band(longint f);
            if (f < band_limit(1)) return band[0];
            if (f < band_limit(3)) return band[1];
            if (f < band_limit(5)) return band[2];
            if (f < band_limit(7)) return band[3];
            return band[4];
        endfunction

        function logic [COLOR_BITS-1:0] blue_gradient(longint f);
            longint r;
            longint g;
            longint b;
            r = (GRAD_RED_TOP * f) >> FRAC_W;
            g = (GRAD_GREEN_TOP * f) >> FRAC_W;
            b = GRAD_BLUE_BASE + ((GRAD_BLUE_SPAN * f) >> FRAC_W);
            return {r[7:0], g[7:0], b[7:0]};
        endfunction

        function logic [COLOR_BITS-1:0] hue_color(longint f);
            longint hue;
            longint s;
            longint t;
            longint u;
            longint x;
            logic [CHANNEL_BITS-1:0] x8;
            hue = ((360 * f) >> (FRAC_W - 8)) + longint'(phase) * 256;
            while (hue >= FULL_TURN) hue = hue - FULL_TURN;
            s = hue / SECTOR;
            t = hue - s * SECTOR;
            u = s[0] ? SECTOR - t : t;
            x = (255 * u) / SECTOR;
            x8 = x[7:0];
            case (s)
                0: return {CHANNEL_MAX, x8, 8'h00};
                1: return {x8, CHANNEL_MAX, 8'h00};
                2: return {8'h00, CHANNEL_MAX, x8};
                3: return {8'h00, x8, CHANNEL_MAX};
                4: return {x8, 8'h00, CHANNEL_MAX};
                default: return {CHANNEL_MAX, 8'h00, x8};
            endcase
        endfunction

        function void note_request(logic op, logic signed [HEIGHT_W-1:0] h);
            longint f;
            if (op == OP_TICK)
            begin
                ticks++;
                if (mode == MODE_RAINBOW)
                begin
                    phase = phase + PHASE_STEP;
                    if (phase >= PHASE_WRAP) phase = phase - PHASE_WRAP;
                    phase_steps++;
                end
            end
            else
            begin
                f = height_fraction(h);
                colors_by_mode[mode]++;
                case (mode)
                    MODE_GRADIENT: pending_colors.push_back(blue_gradient(f));
                    MODE_RAINBOW: pending_colors.push_back(hue_color(f));
                    default: pending_colors.push_back(altitude_band(f));
                endcase
            end
        endfunction

        function void check_color(logic [COLOR_BITS-1:0] actual);
            logic [COLOR_BITS-1:0] expected;
            if (pending_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected color %06h, expected nothing", $time, actual);
                return;
            end
            expected = pending_colors.pop_front();
            checked++;
            if (actual !== expected)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: color mismatch, expected %06h, actual %06h",
                             $time, expected, actual);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic operation;
    logic signed [HEIGHT_W-1:0] height;
    logic out_valid;
    logic out_ready;
    logic [COLOR_BITS-1:0] color;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    bit steady = 1'b0;
    bit hold_off_req = 1'b0;
    int stall_cycles = 0;
    int settings_applied = 0;
    color_scoreboard sb = new();

    height_to_color_mapper DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .height(height),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .color(color),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_color(color);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_ready = steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_colors.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input logic [1:0] mode,
                                     input logic signed [HEIGHT_W-1:0] lo,
                                     input logic signed [HEIGHT_W-1:0] hi,
                                     input band_array_t bands);
        logic [CFG_DATA_BITS-1:0] junk;
        drain_results();
        junk = $urandom;
        write_register(CFG_COLOR_MODE, {junk[CFG_DATA_BITS-1:2], mode});
        junk = $urandom;
        write_register(CFG_MIN_HEIGHT, {junk[CFG_DATA_BITS-1:HEIGHT_W], lo});
        junk = $urandom;
        write_register(CFG_MAX_HEIGHT, {junk[CFG_DATA_BITS-1:HEIGHT_W], hi});
        for (int b = 0; b < NUM_BANDS; b++)
        begin
            junk = $urandom;
            write_register(CFG_INDEX_BITS'(CFG_BAND0 + b),
                           {junk[CFG_DATA_BITS-1:COLOR_BITS], bands[b]});
        end
        settings_applied++;
    endtask

    task automatic send_request(input logic op, input logic signed [HEIGHT_W-1:0] h);
        @(negedge clk);
        in_valid = 1'b1;
        operation = op;
        height = h;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(op, h);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        operation = 1'($urandom);
        height = HEIGHT_W'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    function automatic logic signed [HEIGHT_W-1:0] pick_height(int lo, int hi);
        int r;
        int a;
        int b;
        r = $urandom_range(99);
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        if (r < 40) return HEIGHT_W'($urandom);
        if (r < 80) return HEIGHT_W'(a + int'($urandom_range(b - a)));
        if (r < 92)
        begin
            case ($urandom_range(3))
                0: return HEIGHT_W'(lo);
                1: return HEIGHT_W'(hi);
                2: return HEIGHT_W'(lo - 1);
                default: return HEIGHT_W'(hi + 1);
            endcase
        end
        return $urandom_range(1) ? HEIGHT_W'(HEIGHT_MIN) : HEIGHT_W'(HEIGHT_MAX);
    endfunction

    initial
    begin
        int lo;
        int hi;
        int span;
        int counted;
        bit drained_mid;
        logic [1:0] mode;
        logic op;
        band_array_t bands;

        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_COLOR;
        height = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COLOR_MODE;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Band edges with heights at and next to the band thresholds.
        program_registers(MODE_BANDS, -1000, 1000, DIRECTED_BANDS);
        for (int i = 0; i < 10; i++) send_request(OP_COLOR, HEIGHT_W'(BAND_EDGES[i]));

        // A zero range gives the full fraction for any height.
        program_registers(MODE_BANDS, 5, 5, DIRECTED_BANDS);
        send_request(OP_COLOR, 5);
        send_request(OP_COLOR, HEIGHT_MIN);

        program_registers(MODE_GRADIENT, 1000, -1000, DIRECTED_BANDS);
        send_request(OP_COLOR, 1000);
        send_request(OP_COLOR, 0);
        send_request(OP_COLOR, -1000);
        send_request(OP_COLOR, HEIGHT_MIN);
        send_request(OP_COLOR, HEIGHT_MAX);

        program_registers(MODE_RAINBOW, HEIGHT_MIN, HEIGHT_MAX, DIRECTED_BANDS);
        send_request(OP_COLOR, HEIGHT_MIN);
        send_request(OP_TICK, 0);
        send_request(OP_COLOR, HEIGHT_MIN);
        send_request(OP_COLOR, HEIGHT_MAX);
        send_request(OP_TICK, HEIGHT_MAX);
        send_request(OP_COLOR, 0);

        program_registers(MODE_UNUSED, -100, 100, DIRECTED_BANDS);
        send_request(OP_TICK, 0);
        send_request(OP_COLOR, 50);

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            mode = p[1:0];
            case (p % 5)
                0:
                begin
                    lo = HEIGHT_MIN;
                    hi = HEIGHT_MAX;
                end
                1:
                begin
                    lo = HEIGHT_MAX;
                    hi = HEIGHT_MIN;
                end
                2:
                begin
                    lo = int'($urandom_range(65535)) + HEIGHT_MIN;
                    hi = lo;
                end
                3:
                begin
                    lo = int'($urandom_range(65535)) + HEIGHT_MIN;
                    span = $urandom_range(1, 300);
                    hi = (lo + span > HEIGHT_MAX) ? lo - span : lo + span;
                end
                default:
                begin
                    lo = int'($urandom_range(65535)) + HEIGHT_MIN;
                    hi = int'($urandom_range(65535)) + HEIGHT_MIN;
                end
            endcase
            for (int b = 0; b < NUM_BANDS; b++) bands[b] = COLOR_BITS'($urandom);
            program_registers(mode, HEIGHT_W'(lo), HEIGHT_W'(hi), bands);

            // The receiver stalls while the sender keeps offering requests.
            if (p == 1) hold_off_req = 1'b1;
            steady = (p == 2);
            counted = 0;
            drained_mid = 1'b0;
            while (counted < ITEMS_PER_SETTING)
            begin
                if (p == 3 && !drained_mid && counted >= ITEMS_PER_SETTING / 2)
                begin
                    drained_mid = 1'b1;
                    drain_results();
                end
                if (!steady && $urandom_range(99) < IDLE_PERCENT)
                    pause_sender($urandom_range(1, 30));
                op = ($urandom_range(99) < ((mode == MODE_RAINBOW) ? 45 : 10))
                     ? OP_TICK : OP_COLOR;
                send_request(op, pick_height(lo, hi));
                if (op == OP_COLOR || mode == MODE_RAINBOW) counted++;
            end
            steady = 1'b0;
        end

        drain_results();

        $display("Covered %0d register settings; colors per mode %0d, %0d, %0d, %0d.",
                 settings_applied, sb.colors_by_mode[0], sb.colors_by_mode[1],
                 sb.colors_by_mode[2], sb.colors_by_mode[3]);
        $display("Checked %0d colors; %0d ticks, %0d of them moved the hue phase.",
                 sb.checked, sb.ticks, sb.phase_steps);
        if (sb.mismatches == 0 && sb.pending_colors.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
